[hdl/tlnef_pkg.sv]
package tlnef_pkg;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic mark_line_end;
    logic show_tabs;
    logic show_controls;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_NUMBER_NONBLANK = 3'd0,
    REG_NUMBER_ALL      = 3'd1,
    REG_SQUEEZE_BLANK   = 3'd2,
    REG_MARK_LINE_END   = 3'd3,
    REG_SHOW_TABS       = 3'd4,
    REG_SHOW_CONTROLS   = 3'd5
  } reg_idx_t;

  // what the back end has to emit for one accepted byte
  typedef struct packed {
    logic       num;     // line number and tab first
    logic       dollar;  // '$' before the byte
    logic       caret;   // '^' before chr
    logic [7:0] chr;     // final byte
  } desc_t;

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_TAB,
    PH_DOLLAR,
    PH_CARET,
    PH_CHAR
  } phase_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CAP_I  = 8'h49;
  localparam logic [7:0] CTRL_MAX  = 8'd31;
  localparam logic [7:0] CARET_OFS = 8'd64;
  localparam logic [3:0] BCD_NINE  = 4'd9;

endpackage

[hdl/tlnef_queue.sv]
module tlnef_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  import tlnef_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0)
    else $error("queue popped while empty");
`endif

endmodule

[hdl/tlnef_front.sv]
module tlnef_front #(
  parameter int ND = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_file_start,
  input  tlnef_pkg::cfg_t   cfg,
  output logic              q_push,
  output tlnef_pkg::desc_t  q_desc,
  output logic [4*ND-1:0]   q_count,
  input  logic              q_ready
);
  import tlnef_pkg::*;

  localparam int CW = 4 * ND;

  logic          after_nl_r, after_nl_nxt;
  logic          squeezing_r, squeezing_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_inc;
  logic [ND:0]   carry;

  logic accept, prev_nl, sqz_cur, is_nl, is_tab, blank_pair, drop, num;
  logic is_ctrl;

  // bcd increment, saturating at all nines
  assign carry[0] = 1'b1;
  for (genvar g = 0; g < ND; g++) begin : g_digit
    logic [3:0] d;
    assign d            = count_r[4*g +: 4];
    assign carry[g+1]   = carry[g] & (d >= BCD_NINE);
    assign count_inc[4*g +: 4] = carry[g] ? ((d >= BCD_NINE) ? 4'd0 : d + 4'd1) : d;
  end

  always_comb begin
    accept     = in_valid && q_ready;
    is_nl      = (in_byte == CH_NL);
    is_tab     = (in_byte == CH_TAB);
    is_ctrl    = (in_byte <= CTRL_MAX) && !is_nl && !is_tab;
    prev_nl    = in_file_start ? 1'b1 : after_nl_r;
    sqz_cur    = in_file_start ? 1'b0 : squeezing_r;
    blank_pair = cfg.squeeze_blank && is_nl && prev_nl;
    drop       = blank_pair && sqz_cur;
    num        = (cfg.number_nonblank && prev_nl && !is_nl) ||
                 (cfg.number_all && !cfg.number_nonblank && prev_nl);

    q_desc.num    = num;
    q_desc.dollar = cfg.mark_line_end && is_nl;
    if (cfg.show_tabs && is_tab) begin
      q_desc.caret = 1'b1;
      q_desc.chr   = CH_CAP_I;
    end else if (cfg.show_controls && is_ctrl) begin
      q_desc.caret = 1'b1;
      q_desc.chr   = in_byte + CARET_OFS;
    end else begin
      q_desc.caret = 1'b0;
      q_desc.chr   = in_byte;
    end
    q_count = count_r;

    in_ready = q_ready;
    q_push   = accept && !drop;

    after_nl_nxt  = after_nl_r;
    squeezing_nxt = squeezing_r;
    count_nxt     = count_r;
    if (accept) begin
      after_nl_nxt  = is_nl;
      squeezing_nxt = blank_pair;
      if (num && !drop && !carry[ND]) begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_nl_r  <= 1'b1;
      squeezing_r <= 1'b0;
      count_r     <= {{(CW-1){1'b0}}, 1'b1};
    end else begin
      after_nl_r  <= after_nl_nxt;
      squeezing_r <= squeezing_nxt;
      count_r     <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_only_nl_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !q_push) |-> in_byte == CH_NL)
    else $error("non-newline transaction dropped");
`endif

endmodule

[hdl/tlnef_back.sv]
module tlnef_back #(
  parameter int ND = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tlnef_pkg::desc_t  q_desc,
  input  logic [4*ND-1:0]   q_count,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_of_run
);
  import tlnef_pkg::*;

  localparam int CW = 4 * ND;
  localparam int DW = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [DW-1:0] TOP_DIGIT = DW'(ND - 1);

  phase_t        phase_r, phase_nxt, cur_ph, first_ph;
  logic          started_r, started_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt, eff_d;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          fire;
  logic [CW-1:0] shifted;
  logic [3:0]    digit;
  logic          blank;
  logic [7:0]    emit_byte;
  logic          emit_last;

  always_comb begin
    if (q_desc.num) begin
      first_ph = PH_DIGIT;
    end else if (q_desc.dollar) begin
      first_ph = PH_DOLLAR;
    end else if (q_desc.caret) begin
      first_ph = PH_CARET;
    end else begin
      first_ph = PH_CHAR;
    end
    cur_ph = started_r ? phase_r : first_ph;
    eff_d  = started_r ? dcnt_r : TOP_DIGIT;
    fire   = q_valid && (!out_valid_r || out_ready);
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    started_nxt = started_r;
    dcnt_nxt    = dcnt_r;
    if (fire) begin
      started_nxt = 1'b1;
      case (cur_ph)
        PH_DIGIT: begin
          if (eff_d == '0) begin
            phase_nxt = PH_TAB;
          end else begin
            phase_nxt = PH_DIGIT;
            dcnt_nxt  = eff_d - 1'b1;
          end
        end
        PH_TAB: begin
          if (q_desc.dollar) begin
            phase_nxt = PH_DOLLAR;
          end else if (q_desc.caret) begin
            phase_nxt = PH_CARET;
          end else begin
            phase_nxt = PH_CHAR;
          end
        end
        PH_DOLLAR: begin
          phase_nxt = q_desc.caret ? PH_CARET : PH_CHAR;
        end
        PH_CARET: begin
          phase_nxt = PH_CHAR;
        end
        default: begin
          started_nxt = 1'b0;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    shifted   = q_count >> {eff_d, 2'b00};
    digit     = shifted[3:0];
    // leading zeros become spaces, the units digit always shows
    blank     = (shifted == '0) && (eff_d != '0);
    emit_last = 1'b0;
    case (cur_ph)
      PH_DIGIT: begin
        emit_byte = blank ? CH_SPACE :
                    CH_ZERO + {4'd0, (digit > BCD_NINE) ? BCD_NINE : digit};
      end
      PH_TAB:    emit_byte = CH_TAB;
      PH_DOLLAR: emit_byte = CH_DOLLAR;
      PH_CARET:  emit_byte = CH_CARET;
      default: begin
        emit_byte = q_desc.chr;
        emit_last = 1'b1;
      end
    endcase
    q_pop = fire && emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHAR;
      started_r   <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      started_r <= started_nxt;
      dcnt_r    <= dcnt_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_run_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> q_valid)
    else $error("queue head lost in the middle of a run");

  a_digits_need_num: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r && (phase_r == PH_DIGIT || phase_r == PH_TAB)) |-> q_desc.num)
    else $error("line number emitted for an entry without numbering");
`endif

endmodule

[hdl/text_line_number_escape_filter.sv]
// Byte filter with cat-style output options: optional line numbers (every line or non-empty
// lines only, NUMBER_DIGITS space-padded decimal digits and a tab, counter saturating at all
// nines and running on across files), squeezing of repeated empty lines, '$' before each
// newline, tab shown as ^I and other control bytes as ^ plus byte+64. Options are six 1-bit
// registers at byte addresses 0,4,..,20 (bit 0 used), written by the user only while the
// block is idle; the block does not enforce it. in_file_start on a byte restarts line-start
// and squeeze tracking but not the counter. A byte maps to n output bytes (1 for a plain
// byte, up to NUMBER_DIGITS+3); plain bytes stream at one per cycle while out_ready is
// high. The input side classifies a byte combinationally, drops squeezed newlines so they
// give no output, and runs ahead of the output side by up to two bytes in a two-entry queue.
module text_line_number_escape_filter #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlnef_pkg::*;

  localparam int CW = 4 * NUMBER_DIGITS;
  localparam int QW = $bits(desc_t) + CW;

  cfg_t          cfg_r, cfg_nxt;
  reg_idx_t      reg_idx;
  logic          wr_en;
  logic          rd_bit;

  logic          f_push, f_ready;
  desc_t         f_desc;
  logic [CW-1:0] f_count;
  logic          b_valid, b_pop;
  logic [QW-1:0] b_data;
  desc_t         b_desc;
  logic [CW-1:0] b_count;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    rd_bit  = 1'b0;
    case (reg_idx)
      REG_NUMBER_NONBLANK: begin
        rd_bit = cfg_r.number_nonblank;
        if (wr_en) cfg_nxt.number_nonblank = pwdata[0];
      end
      REG_NUMBER_ALL: begin
        rd_bit = cfg_r.number_all;
        if (wr_en) cfg_nxt.number_all = pwdata[0];
      end
      REG_SQUEEZE_BLANK: begin
        rd_bit = cfg_r.squeeze_blank;
        if (wr_en) cfg_nxt.squeeze_blank = pwdata[0];
      end
      REG_MARK_LINE_END: begin
        rd_bit = cfg_r.mark_line_end;
        if (wr_en) cfg_nxt.mark_line_end = pwdata[0];
      end
      REG_SHOW_TABS: begin
        rd_bit = cfg_r.show_tabs;
        if (wr_en) cfg_nxt.show_tabs = pwdata[0];
      end
      REG_SHOW_CONTROLS: begin
        rd_bit = cfg_r.show_controls;
        if (wr_en) cfg_nxt.show_controls = pwdata[0];
      end
      default: begin
        rd_bit = 1'b0;
      end
    endcase
    prdata = {31'd0, rd_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tlnef_front #(
    .ND (NUMBER_DIGITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_file_start (in_file_start),
    .cfg           (cfg_r),
    .q_push        (f_push),
    .q_desc        (f_desc),
    .q_count       (f_count),
    .q_ready       (f_ready)
  );

  tlnef_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_desc, f_count}),
    .push_ready (f_ready),
    .pop        (b_pop),
    .head_valid (b_valid),
    .head_data  (b_data)
  );

  assign b_desc  = desc_t'(b_data[QW-1:CW]);
  assign b_count = b_data[CW-1:0];

  tlnef_back #(
    .ND (NUMBER_DIGITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (b_valid),
    .q_desc          (b_desc),
    .q_count         (b_count),
    .q_pop           (b_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
